[rtl/sfit_pkg.sv]
// Shared types and constants of the segment/frustum selection test.
// No dependencies; sfit_if, sfit_front, sfit_back and the top level use this package.
package sfit_pkg;

  localparam int FIELD_W     = 21;
  localparam int CFG_W       = 63;
  localparam int CFG_IDX_W   = 4;
  localparam int NUM_CORNERS = 8;
  localparam int NUM_FACES   = 4;
  localparam int NUM_TRIS    = 2 * NUM_FACES;

  typedef enum logic [1:0] {
    CAUSE_PLANE_REJECT = 2'd0,
    CAUSE_ALL_INSIDE   = 2'd1,
    CAUSE_TRI_HIT      = 2'd2,
    CAUSE_NO_HIT       = 2'd3
  } cause_e;

  typedef enum logic {
    OP_POINT   = 1'b0,
    OP_SEGMENT = 1'b1
  } op_e;

  // Outcome of the plane classification; decided means no triangle test is needed.
  typedef struct packed {
    logic   decided;
    logic   inside_res;
    cause_e cause;
  } verdict_t;

  typedef logic [NUM_CORNERS-1:0][CFG_W-1:0] corners_t;

  // Corner register indices of each side face: top, bottom, right, left.
  localparam logic [2:0] FACE_CORNER [NUM_FACES][4] = '{
    '{3'd0, 3'd1, 3'd4, 3'd5},
    '{3'd3, 3'd2, 3'd7, 3'd6},
    '{3'd1, 3'd3, 3'd5, 3'd7},
    '{3'd2, 3'd0, 3'd6, 3'd4}
  };

endpackage

[rtl/sfit_if.sv]
// Valid/ready channel interfaces for requests and results of the selection test.
// Depends on sfit_pkg for field widths and the cause type.
interface sfit_req_if;
  logic                                valid;
  logic                                ready;
  logic                                op;
  logic signed [sfit_pkg::FIELD_W-1:0] first_x;
  logic signed [sfit_pkg::FIELD_W-1:0] first_y;
  logic signed [sfit_pkg::FIELD_W-1:0] first_z;
  logic signed [sfit_pkg::FIELD_W-1:0] second_x;
  logic signed [sfit_pkg::FIELD_W-1:0] second_y;
  logic signed [sfit_pkg::FIELD_W-1:0] second_z;

  modport source (output valid, op, first_x, first_y, first_z,
                  second_x, second_y, second_z, input ready);
  modport sink   (input valid, op, first_x, first_y, first_z,
                  second_x, second_y, second_z, output ready);
endinterface

interface sfit_res_if;
  logic             valid;
  logic             ready;
  logic             inside_res;
  sfit_pkg::cause_e cause;

  modport source (output valid, inside_res, cause, input ready);
  modport sink   (input valid, inside_res, cause, output ready);
endinterface

[rtl/sfit_front.sv]
// Front part: accepts requests, evaluates the four face planes for both ends
// and classifies the request. Depends on sfit_pkg and sfit_req_if.
module sfit_front #(
  parameter int COORD_BITS = 21
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sfit_pkg::corners_t          corners_i,
  sfit_req_if.sink                    req_i,
  output logic                        push_valid_o,
  input  logic                        push_ready_i,
  output sfit_pkg::verdict_t          push_verdict_o,
  output logic [6*COORD_BITS-1:0]     push_coords_o
);
  import sfit_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int CW = CB + 1;
  localparam int SW = CB + 2;
  localparam int NW = 2 * CB + 3;
  localparam int DW = CB + 4;
  localparam int LW = CB + 2;
  localparam int HW = NW - LW;
  localparam int PW = 3 * CB + 9;
  localparam int NST = 4;

  typedef logic signed [CB-1:0] crd_t;

  function automatic logic signed [NW-1:0] xterm(input logic signed [CW-1:0] a,
                                                 input logic signed [CW-1:0] b,
                                                 input logic signed [CW-1:0] c,
                                                 input logic signed [CW-1:0] d);
    logic signed [NW-1:0] ab;
    logic signed [NW-1:0] cd;
    ab = a * b;
    cd = c * d;
    return ab - cd;
  endfunction

  crd_t                 corner [NUM_CORNERS][3];
  logic signed [NW-1:0] n_d [NUM_FACES][3];
  logic signed [NW-1:0] n_q [NUM_FACES][3];
  logic signed [SW-1:0] s_d [NUM_FACES][3];
  logic signed [SW-1:0] s_q [NUM_FACES][3];

  logic                 v_q  [NST];
  logic                 op_q [NST];
  crd_t                 p_q  [NST][2][3];

  logic signed [DW-1:0]    d_pl   [NUM_FACES][2][3];
  logic signed [LW+DW:0]   plo_q  [NUM_FACES][2][3];
  logic signed [HW+DW-1:0] phi_q  [NUM_FACES][2][3];
  logic signed [PW-1:0]    comp_q [NUM_FACES][2][3];
  logic                    neg_q  [NUM_FACES][2];
  logic                    pos_q  [NUM_FACES][2];

  logic en;

  assign en          = !v_q[NST-1] || push_ready_i;
  assign req_i.ready = en;

  always_comb begin
    for (int k = 0; k < NUM_CORNERS; k++) begin
      for (int i = 0; i < 3; i++) begin
        corner[k][i] = crd_t'(corners_i[k][i*CB +: CB]);
      end
    end
  end

  // Face normals and corner sums follow the corner registers.
  always_comb begin
    logic signed [CW-1:0] ea [3];
    logic signed [CW-1:0] eb [3];
    for (int f = 0; f < NUM_FACES; f++) begin
      for (int i = 0; i < 3; i++) begin
        ea[i] = CW'(corner[FACE_CORNER[f][1]][i]) - CW'(corner[FACE_CORNER[f][0]][i]);
        eb[i] = CW'(corner[FACE_CORNER[f][2]][i]) - CW'(corner[FACE_CORNER[f][0]][i]);
        s_d[f][i] = SW'(corner[FACE_CORNER[f][0]][i]) + SW'(corner[FACE_CORNER[f][1]][i])
                  + SW'(corner[FACE_CORNER[f][2]][i]) + SW'(corner[FACE_CORNER[f][3]][i]);
      end
      n_d[f][0] = xterm(ea[1], eb[2], ea[2], eb[1]);
      n_d[f][1] = xterm(ea[2], eb[0], ea[0], eb[2]);
      n_d[f][2] = xterm(ea[0], eb[1], ea[1], eb[0]);
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d;
    s_q <= s_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NST; s++) v_q[s] <= 1'b0;
    end else if (en) begin
      v_q[0] <= req_i.valid;
      for (int s = 1; s < NST; s++) v_q[s] <= v_q[s-1];
    end
  end

  always_comb begin
    for (int f = 0; f < NUM_FACES; f++) begin
      for (int pt = 0; pt < 2; pt++) begin
        for (int i = 0; i < 3; i++) begin
          d_pl[f][pt][i] = DW'(s_q[f][i]) - (DW'(p_q[0][pt][i]) <<< 2);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [PW-1:0] val;
    if (en) begin
      op_q[0]      <= req_i.op;
      p_q[0][0][0] <= crd_t'(req_i.first_x[CB-1:0]);
      p_q[0][0][1] <= crd_t'(req_i.first_y[CB-1:0]);
      p_q[0][0][2] <= crd_t'(req_i.first_z[CB-1:0]);
      p_q[0][1][0] <= crd_t'(req_i.second_x[CB-1:0]);
      p_q[0][1][1] <= crd_t'(req_i.second_y[CB-1:0]);
      p_q[0][1][2] <= crd_t'(req_i.second_z[CB-1:0]);
      for (int s = 1; s < NST; s++) begin
        op_q[s] <= op_q[s-1];
        p_q[s]  <= p_q[s-1];
      end
      for (int f = 0; f < NUM_FACES; f++) begin
        for (int pt = 0; pt < 2; pt++) begin
          // Each product is split so that no multiplier is wider than about 25 bits.
          for (int i = 0; i < 3; i++) begin
            plo_q[f][pt][i]  <= $signed({1'b0, n_q[f][i][LW-1:0]}) * d_pl[f][pt][i];
            phi_q[f][pt][i]  <= $signed(n_q[f][i][NW-1:LW]) * d_pl[f][pt][i];
            comp_q[f][pt][i] <= (PW'(phi_q[f][pt][i]) <<< LW) + PW'(plo_q[f][pt][i]);
          end
          val = comp_q[f][pt][0] + comp_q[f][pt][1] + comp_q[f][pt][2];
          neg_q[f][pt] <= val[PW-1];
          pos_q[f][pt] <= !val[PW-1] && (val != '0);
        end
      end
    end
  end

  always_comb begin
    logic any_neg_a;
    logic any_both;
    logic all_pos;
    any_neg_a = 1'b0;
    any_both  = 1'b0;
    all_pos   = 1'b1;
    for (int f = 0; f < NUM_FACES; f++) begin
      any_neg_a = any_neg_a || neg_q[f][0];
      any_both  = any_both || (neg_q[f][0] && neg_q[f][1]);
      all_pos   = all_pos && pos_q[f][0] && pos_q[f][1];
    end
    push_verdict_o = '{decided: 1'b0, inside_res: 1'b0, cause: CAUSE_NO_HIT};
    if (op_q[NST-1] == OP_POINT) begin
      push_verdict_o.decided    = 1'b1;
      push_verdict_o.inside_res = !any_neg_a;
      push_verdict_o.cause      = any_neg_a ? CAUSE_PLANE_REJECT : CAUSE_ALL_INSIDE;
    end else if (any_both) begin
      push_verdict_o.decided = 1'b1;
      push_verdict_o.cause   = CAUSE_PLANE_REJECT;
    end else if (all_pos) begin
      push_verdict_o.decided    = 1'b1;
      push_verdict_o.inside_res = 1'b1;
      push_verdict_o.cause      = CAUSE_ALL_INSIDE;
    end
    for (int pt = 0; pt < 2; pt++) begin
      for (int i = 0; i < 3; i++) begin
        push_coords_o[(pt*3+i)*CB +: CB] = p_q[NST-1][pt][i];
      end
    end
  end

  assign push_valid_o = v_q[NST-1];

endmodule

[rtl/sfit_fifo.sv]
// Short register queue between the front and back parts of the selection test.
// Depends on nothing but its parameters.
module sfit_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [WIDTH-1:0] rd_data_o
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;

  assign wr_ready_o = (count_q != CNT_W'(DEPTH));
  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = mem_q[rptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push) begin
      wptr_d = (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");
  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count did not follow a lone write");
`endif

endmodule

[rtl/sfit_back.sv]
// Back part: runs the line against the eight face triangles and forms the result.
// Depends on sfit_pkg and sfit_res_if.
module sfit_back #(
  parameter int COORD_BITS = 21
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  sfit_pkg::corners_t      corners_i,
  input  logic                    pop_valid_i,
  output logic                    pop_ready_o,
  input  sfit_pkg::verdict_t      pop_verdict_i,
  input  logic [6*COORD_BITS-1:0] pop_coords_i,
  sfit_res_if.source              res_o
);
  import sfit_pkg::*;

  localparam int CB  = COORD_BITS;
  localparam int CW  = CB + 1;
  localparam int NW  = 2 * CB + 3;
  localparam int LW  = CB + 2;
  localparam int HW  = NW - LW;
  localparam int PW  = 3 * CB + 9;
  localparam int NST = 6;

  typedef logic signed [CB-1:0] crd_t;

  function automatic logic signed [NW-1:0] xterm(input logic signed [CW-1:0] a,
                                                 input logic signed [CW-1:0] b,
                                                 input logic signed [CW-1:0] c,
                                                 input logic signed [CW-1:0] d);
    logic signed [NW-1:0] ab;
    logic signed [NW-1:0] cd;
    ab = a * b;
    cd = c * d;
    return ab - cd;
  endfunction

  crd_t                 corner [NUM_CORNERS][3];
  crd_t                 v1 [NUM_TRIS][3];
  logic signed [CW-1:0] e1 [NUM_TRIS][3];
  logic signed [CW-1:0] e2 [NUM_TRIS][3];

  logic     v_q  [NST];
  verdict_t vr_q [NST];
  crd_t     p_q  [2][3];

  logic signed [CW-1:0] dir_d  [3];
  logic signed [CW-1:0] tv_d   [NUM_TRIS][3];
  logic signed [CW-1:0] dir_q  [3];
  logic signed [CW-1:0] tvec_q [NUM_TRIS][3];
  logic signed [NW-1:0] pvec_q [NUM_TRIS][3];
  logic signed [NW-1:0] qvec_q [NUM_TRIS][3];

  // Operands of the three dot products: det, u numerator, v numerator.
  logic signed [CW-1:0] opa [NUM_TRIS][3][3];
  logic signed [NW-1:0] opb [NUM_TRIS][3][3];

  logic signed [LW+CW:0]   plo_q  [NUM_TRIS][3][3];
  logic signed [HW+CW-1:0] phi_q  [NUM_TRIS][3][3];
  logic signed [PW-1:0]    comp_q [NUM_TRIS][3][3];
  logic signed [PW-1:0]    dot_q  [NUM_TRIS][3];
  logic signed [PW:0]      dn_q   [NUM_TRIS][3];
  logic                    dz_q   [NUM_TRIS];

  logic   res_valid_q;
  logic   res_inside_q;
  cause_e res_cause_q;
  logic   en;

  assign en          = !res_valid_q || res_o.ready;
  assign pop_ready_o = en;

  always_comb begin
    int f;
    logic [2:0] k0, k1, k2;
    for (int k = 0; k < NUM_CORNERS; k++) begin
      for (int i = 0; i < 3; i++) begin
        corner[k][i] = crd_t'(corners_i[k][i*CB +: CB]);
      end
    end
    for (int t = 0; t < NUM_TRIS; t++) begin
      f  = t / 2;
      k0 = FACE_CORNER[f][0];
      k1 = (t % 2 == 1) ? FACE_CORNER[f][2] : FACE_CORNER[f][1];
      k2 = (t % 2 == 1) ? FACE_CORNER[f][3] : FACE_CORNER[f][2];
      for (int i = 0; i < 3; i++) begin
        v1[t][i] = corner[k0][i];
        e1[t][i] = CW'(corner[k1][i]) - CW'(corner[k0][i]);
        e2[t][i] = CW'(corner[k2][i]) - CW'(corner[k0][i]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dir_d[i] = CW'(p_q[1][i]) - CW'(p_q[0][i]);
    end
    for (int t = 0; t < NUM_TRIS; t++) begin
      for (int i = 0; i < 3; i++) begin
        tv_d[t][i] = CW'(p_q[0][i]) - CW'(v1[t][i]);
        opa[t][0][i] = e1[t][i];
        opb[t][0][i] = pvec_q[t][i];
        opa[t][1][i] = tvec_q[t][i];
        opb[t][1][i] = pvec_q[t][i];
        opa[t][2][i] = dir_q[i];
        opb[t][2][i] = qvec_q[t][i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NST; s++) v_q[s] <= 1'b0;
      res_valid_q <= 1'b0;
    end else if (en) begin
      v_q[0] <= pop_valid_i;
      for (int s = 1; s < NST; s++) v_q[s] <= v_q[s-1];
      res_valid_q <= v_q[NST-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vr_q[0] <= pop_verdict_i;
      for (int s = 1; s < NST; s++) vr_q[s] <= vr_q[s-1];
      for (int pt = 0; pt < 2; pt++) begin
        for (int i = 0; i < 3; i++) begin
          p_q[pt][i] <= crd_t'(pop_coords_i[(pt*3+i)*CB +: CB]);
        end
      end
      dir_q <= dir_d;
      for (int t = 0; t < NUM_TRIS; t++) begin
        tvec_q[t] <= tv_d[t];
        pvec_q[t][0] <= xterm(dir_d[1], e2[t][2], dir_d[2], e2[t][1]);
        pvec_q[t][1] <= xterm(dir_d[2], e2[t][0], dir_d[0], e2[t][2]);
        pvec_q[t][2] <= xterm(dir_d[0], e2[t][1], dir_d[1], e2[t][0]);
        qvec_q[t][0] <= xterm(tv_d[t][1], e1[t][2], tv_d[t][2], e1[t][1]);
        qvec_q[t][1] <= xterm(tv_d[t][2], e1[t][0], tv_d[t][0], e1[t][2]);
        qvec_q[t][2] <= xterm(tv_d[t][0], e1[t][1], tv_d[t][1], e1[t][0]);
        for (int k = 0; k < 3; k++) begin
          for (int i = 0; i < 3; i++) begin
            plo_q[t][k][i]  <= $signed({1'b0, opb[t][k][i][LW-1:0]}) * opa[t][k][i];
            phi_q[t][k][i]  <= $signed(opb[t][k][i][NW-1:LW]) * opa[t][k][i];
            comp_q[t][k][i] <= (PW'(phi_q[t][k][i]) <<< LW) + PW'(plo_q[t][k][i]);
          end
          dot_q[t][k] <= comp_q[t][k][0] + comp_q[t][k][1] + comp_q[t][k][2];
          // A negative determinant flips the signs of all three values.
          dn_q[t][k] <= dot_q[t][0][PW-1] ? -((PW+1)'(dot_q[t][k])) : (PW+1)'(dot_q[t][k]);
        end
        dz_q[t] <= (dot_q[t][0] == '0);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    logic               any_hit;
    logic signed [PW+2:0] du;
    logic signed [PW+2:0] duv;
    if (en) begin
      any_hit = 1'b0;
      for (int t = 0; t < NUM_TRIS; t++) begin
        du  = (PW+3)'(dn_q[t][0]) - (PW+3)'(dn_q[t][1]);
        duv = du - (PW+3)'(dn_q[t][2]);
        any_hit = any_hit || (!dz_q[t] && !dn_q[t][1][PW] && !dn_q[t][2][PW]
                              && !du[PW+2] && !duv[PW+2]);
      end
      if (vr_q[NST-1].decided) begin
        res_inside_q <= vr_q[NST-1].inside_res;
        res_cause_q  <= vr_q[NST-1].cause;
      end else begin
        res_inside_q <= any_hit;
        res_cause_q  <= any_hit ? CAUSE_TRI_HIT : CAUSE_NO_HIT;
      end
    end
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.inside_res = res_inside_q;
  assign res_o.cause      = res_cause_q;

endmodule

[rtl/segment_frustum_intersection_test_top.sv]
// Top level of the segment/frustum selection test: corner registers, front part,
// queue and back part. Depends on sfit_pkg, sfit_if, sfit_front, sfit_fifo, sfit_back.
//
// Usage. Eight corner registers describe the frustum; each is written through the
// plain write port (cfg_we_i, cfg_idx_i, cfg_data_i). The user must write them only
// while no request is in flight; the block does not enforce this. An index of eight or
// more is ignored. A request on req_i carries an operation (point test on the first
// end, or segment test) and two ends; each request gives exactly one result on res_o
// with the selection flag and the cause. Throughput is one request per cycle while
// results are taken, set by the fully pipelined plane and triangle arithmetic. A
// request runs through three further front stages, the queue and seven back stages including
// the output register. The front part evaluates all four face planes for both ends and
// decides points, plane rejects and fully inside segments; the back part evaluates
// the eight face triangles for every request and keeps request order.
// Reset clears the corner registers, the pipeline valid bits and the queue.
// When the receiver stalls, the output register holds its result, the back part
// stops, the queue fills and only then does the front part withdraw req_i.ready.
// The face normal registers follow a corner write in the cycle after it is stored.
module segment_frustum_intersection_test_top #(
  parameter int COORD_BITS = 21,
  parameter int FRAC_BITS  = 10,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sfit_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sfit_pkg::CFG_W-1:0]      cfg_data_i,
  sfit_req_if.sink                        req_i,
  sfit_res_if.source                      res_o
);
  import sfit_pkg::*;

  // Every decision is a sign test of a homogeneous expression, so the binary
  // point only documents the coordinate format.
  localparam int ENTRY_W = $bits(verdict_t) + 6 * COORD_BITS + 0 * FRAC_BITS;

  corners_t              cfg_q;
  logic                  push_valid, push_ready, pop_valid, pop_ready;
  verdict_t              push_verdict, pop_verdict;
  logic [6*COORD_BITS-1:0] push_coords, pop_coords;
  logic [ENTRY_W-1:0]    rd_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      for (int k = 0; k < NUM_CORNERS; k++) begin
        if (cfg_idx_i == CFG_IDX_W'(k)) begin
          cfg_q[k] <= cfg_data_i;
        end
      end
    end
  end

  sfit_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .corners_i      (cfg_q),
    .req_i          (req_i),
    .push_valid_o   (push_valid),
    .push_ready_i   (push_ready),
    .push_verdict_o (push_verdict),
    .push_coords_o  (push_coords)
  );

  sfit_fifo #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push_valid),
    .wr_ready_o (push_ready),
    .wr_data_i  ({push_verdict, push_coords}),
    .rd_valid_o (pop_valid),
    .rd_ready_i (pop_ready),
    .rd_data_o  (rd_entry)
  );

  assign pop_verdict = verdict_t'(rd_entry[ENTRY_W-1 -: $bits(verdict_t)]);
  assign pop_coords  = rd_entry[6*COORD_BITS-1:0];

  sfit_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .corners_i     (cfg_q),
    .pop_valid_i   (pop_valid),
    .pop_ready_o   (pop_ready),
    .pop_verdict_i (pop_verdict),
    .pop_coords_i  (pop_coords),
    .res_o         (res_o)
  );

`ifndef SYNTHESIS
  a_selected_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (res_o.cause == CAUSE_ALL_INSIDE || res_o.cause == CAUSE_TRI_HIT))
      |-> res_o.inside_res)
    else $error("selected cause without selection flag");
  a_rejected_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (res_o.cause == CAUSE_PLANE_REJECT || res_o.cause == CAUSE_NO_HIT))
      |-> !res_o.inside_res)
    else $error("rejected cause with selection flag");
`endif

endmodule
